>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked while out of reset
`define TFB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tfb assertion failed");

// property checked on every edge, reset included
`define TFB_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tfb assertion failed");

`endif

>>> hw/rtl/tfb_pkg.sv
// types and constants of the telemetry frame builder
// no dependencies
`default_nettype none

package tfb_pkg;

    typedef logic [7:0] t_byte;

    localparam t_byte SYNC_RESET      = 8'hAA;
    localparam int    QUEUE_DEPTH_DEF = 4;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam logic [1:0] HDR_SYNC = 2'd0;
    localparam logic [1:0] HDR_DEST = 2'd1;
    localparam logic [1:0] HDR_ID   = 2'd2;
    localparam logic [1:0] HDR_LEN  = 2'd3;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_DATA,
        CMD_ERROR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind kind;
        t_byte     data;
        t_byte     frame_id;
        t_byte     length;
        logic      last;
    } t_cmd;

    typedef enum logic [1:0] {
        PH_BYTE,
        PH_SUM,
        PH_ADD
    } t_phase;

endpackage

`default_nettype wire

>>> hw/rtl/tfb_stream_if.sv
// valid/ready channel interfaces for input items and frame bytes
// depends on tfb_pkg
`default_nettype none

interface tfb_in_if import tfb_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  operation;
    t_byte dest_addr;
    t_byte frame_id;
    t_byte payload_length;
    t_byte payload_byte;

    modport source (
        output valid, operation, dest_addr, frame_id, payload_length, payload_byte,
        input  ready
    );
    modport sink (
        input  valid, operation, dest_addr, frame_id, payload_length, payload_byte,
        output ready
    );
endinterface

interface tfb_out_if import tfb_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  frame_end;
    logic  result_last;
    logic  protocol_error;

    modport source (
        output valid, out_byte, frame_end, result_last, protocol_error,
        input  ready
    );
    modport sink (
        input  valid, out_byte, frame_end, result_last, protocol_error,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/telemetry_frame_builder.sv
// telemetry frame builder: an accepted item goes into a command queue of QUEUE_DEPTH
// entries, which lets new items in while bytes are still going out; frame bytes leave
// through the output register, one byte a cycle unless stalled; a payload byte gives one
// byte, a start four header bytes, six for zero length, and a closing payload byte three
// reset: no frame open, sums zero, sync byte 0xAA, queue and output register empty
// depends on tfb_pkg, tfb_stream_if, tfb_front, tfb_queue, tfb_back
`default_nettype none

module telemetry_frame_builder import tfb_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_wr_en,
    input  wire t_byte i_cfg_wr_data,
    tfb_in_if.sink     i_in,
    tfb_out_if.source  o_out
);

    logic q_full, q_push, q_valid, q_pop;
    t_cmd front_cmd, head_cmd;

    tfb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in.valid),
        .i_operation      (i_in.operation),
        .i_dest_addr      (i_in.dest_addr),
        .i_frame_id       (i_in.frame_id),
        .i_payload_length (i_in.payload_length),
        .i_payload_byte   (i_in.payload_byte),
        .o_ready          (i_in.ready),
        .i_full           (q_full),
        .o_push           (q_push),
        .o_cmd            (front_cmd)
    );

    tfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (q_pop)
    );

    tfb_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_head_valid     (q_valid),
        .i_head           (head_cmd),
        .o_pop            (q_pop),
        .o_valid          (o_out.valid),
        .i_ready          (o_out.ready),
        .o_out_byte       (o_out.out_byte),
        .o_frame_end      (o_out.frame_end),
        .o_result_last    (o_out.result_last),
        .o_protocol_error (o_out.protocol_error)
    );

endmodule

`default_nettype wire

>>> hw/rtl/tfb_front.sv
// front end: takes input items, tracks the open frame and issues commands
// depends on tfb_pkg
`default_nettype none

module tfb_front import tfb_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire logic  i_operation,
    input  wire t_byte i_dest_addr,
    input  wire t_byte i_frame_id,
    input  wire t_byte i_payload_length,
    input  wire t_byte i_payload_byte,
    output logic       o_ready,
    input  wire logic  i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic  r_frame_open, n_frame_open;
    t_byte r_bytes_left, n_bytes_left;
    logic  accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    always_comb begin
        n_frame_open   = r_frame_open;
        n_bytes_left   = r_bytes_left;
        o_cmd.kind     = CMD_ERROR;
        o_cmd.data     = '0;
        o_cmd.frame_id = '0;
        o_cmd.length   = '0;
        o_cmd.last     = 1'b1;
        if (i_operation == OP_START) begin
            o_cmd.kind     = CMD_START;
            o_cmd.data     = i_dest_addr;
            o_cmd.frame_id = i_frame_id;
            o_cmd.length   = i_payload_length;
            o_cmd.last     = (i_payload_length == 8'd0);
            n_frame_open   = (i_payload_length != 8'd0);
            n_bytes_left   = i_payload_length;
        end else if (r_frame_open) begin
            o_cmd.kind   = CMD_DATA;
            o_cmd.data   = i_payload_byte;
            o_cmd.last   = (r_bytes_left == 8'd1);
            n_bytes_left = r_bytes_left - 8'd1;
            if (r_bytes_left == 8'd1) begin
                n_frame_open = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_bytes_left <= '0;
        end else if (accept) begin
            r_frame_open <= n_frame_open;
            r_bytes_left <= n_bytes_left;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/tfb_queue.sv
// short command queue between front end and byte sequencer
// depends on tfb_pkg
`default_nettype none

module tfb_queue import tfb_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_cmd,
    input  wire logic i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/tfb_back.sv
// byte sequencer: expands commands into frame bytes, keeps both checks,
// holds the sync register and the output register; depends on tfb_pkg
`default_nettype none

module tfb_back import tfb_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_wr_en,
    input  wire t_byte i_cfg_wr_data,
    input  wire logic  i_head_valid,
    input  wire t_cmd  i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_byte      o_out_byte,
    output logic       o_frame_end,
    output logic       o_result_last,
    output logic       o_protocol_error
);

    t_byte      r_sync;
    t_byte      r_sum, n_sum;
    t_byte      r_add, n_add;
    t_phase     r_phase, n_phase;
    logic [1:0] r_hdr_idx, n_hdr_idx;
    logic       r_valid;
    t_byte      r_out_byte;
    logic       r_frame_end, r_result_last, r_protocol_error;

    logic  load, go, done, fend, perr;
    t_byte byte_val, base_sum, base_add;

    assign load = !r_valid || i_ready;
    assign go   = i_head_valid && load;

    always_comb begin
        n_phase   = r_phase;
        n_hdr_idx = r_hdr_idx;
        n_sum     = r_sum;
        n_add     = r_add;
        byte_val  = '0;
        done      = 1'b0;
        fend      = 1'b0;
        perr      = 1'b0;
        base_sum  = r_sum;
        base_add  = r_add;
        case (r_phase)
            PH_BYTE: begin
                case (i_head.kind)
                    CMD_START: begin
                        case (r_hdr_idx)
                            HDR_SYNC: begin
                                byte_val = r_sync;
                                base_sum = '0;
                                base_add = '0;
                            end
                            HDR_DEST: byte_val = i_head.data;
                            HDR_ID:   byte_val = i_head.frame_id;
                            HDR_LEN:  byte_val = i_head.length;
                            default:  byte_val = '0;
                        endcase
                        if (r_hdr_idx == HDR_LEN) begin
                            n_hdr_idx = HDR_SYNC;
                            if (i_head.last) begin
                                n_phase = PH_SUM;
                            end else begin
                                done = 1'b1;
                            end
                        end else begin
                            n_hdr_idx = r_hdr_idx + 2'd1;
                        end
                    end
                    CMD_DATA: begin
                        byte_val = i_head.data;
                        if (i_head.last) begin
                            n_phase = PH_SUM;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    default: begin
                        done = 1'b1;
                        perr = 1'b1;
                    end
                endcase
                if (i_head.kind != CMD_ERROR) begin
                    n_sum = base_sum + byte_val;
                    n_add = base_add + n_sum;
                end
            end
            PH_SUM: begin
                byte_val = r_sum;
                n_phase  = PH_ADD;
            end
            PH_ADD: begin
                byte_val = r_add;
                fend     = 1'b1;
                done     = 1'b1;
                n_phase  = PH_BYTE;
            end
            default: begin
                n_phase = PH_BYTE;
            end
        endcase
    end

    assign o_pop = go && done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync    <= SYNC_RESET;
            r_sum     <= '0;
            r_add     <= '0;
            r_phase   <= PH_BYTE;
            r_hdr_idx <= HDR_SYNC;
            r_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_sync <= i_cfg_wr_data;
            end
            if (go) begin
                r_sum     <= n_sum;
                r_add     <= n_add;
                r_phase   <= n_phase;
                r_hdr_idx <= n_hdr_idx;
                r_valid   <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out_byte       <= byte_val;
            r_frame_end      <= fend;
            r_result_last    <= done;
            r_protocol_error <= perr;
        end
    end

    assign o_valid          = r_valid;
    assign o_out_byte       = r_out_byte;
    assign o_frame_end      = r_frame_end;
    assign o_result_last    = r_result_last;
    assign o_protocol_error = r_protocol_error;

endmodule

`default_nettype wire

>>> hw/rtl/tfb_checker.sv
// port-level checks on the frame builder output channel, bound to the top level
// depends on tfb_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tfb_checker import tfb_pkg::*; (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    input wire logic  i_out_valid,
    input wire logic  i_out_ready,
    input wire t_byte i_out_byte,
    input wire logic  i_frame_end,
    input wire logic  i_result_last,
    input wire logic  i_protocol_error
);

    // stalled transfer keeps its byte
    `TFB_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) && $stable(i_frame_end))
    // closing check byte ends its item
    `TFB_ASSERT(a_end_is_last, i_clk, i_rst_n, i_out_valid && i_frame_end |-> i_result_last)
    // dropped payload gives a single zero result
    `TFB_ASSERT(a_err_shape, i_clk, i_rst_n, i_out_valid && i_protocol_error |-> i_result_last && !i_frame_end && (i_out_byte == 8'd0))
    // output empty straight after reset
    `TFB_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind telemetry_frame_builder tfb_checker u_tfb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_byte       (o_out.out_byte),
    .i_frame_end      (o_out.frame_end),
    .i_result_last    (o_out.result_last),
    .i_protocol_error (o_out.protocol_error)
);

`default_nettype wire
